>>> rtl/core/letter_register_interpreter_unit_macros.svh
// ---------------------------------------------------------------------------
// letter_register_interpreter_unit_macros
// assertion macros shared by the checker
// ---------------------------------------------------------------------------
`ifndef LETTER_REGISTER_INTERPRETER_UNIT_MACROS_SVH
`define LETTER_REGISTER_INTERPRETER_UNIT_MACROS_SVH

// implication checked outside reset
`define LRI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define LRI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds through reset
`define LRI_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lri_pkg.sv
// ---------------------------------------------------------------------------
// lri_pkg
// types, codes and helpers of the letter register interpreter
// ---------------------------------------------------------------------------
`default_nettype none

package lri_pkg;

    localparam int NUM_VARS_DEF   = 26;
    localparam int NEST_LIMIT_DEF = 255;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 4;
    localparam int KIND_W = 3;
    localparam int VIDX_W = 5;
    localparam int CMP_W  = 3;
    localparam int JOIN_W = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PRINT   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_ADD     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SUB     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_MUL     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DIV     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_MOD     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_IF      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_ENDIF   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_ELSE    = 4'd9;
    localparam logic [CMD_W-1:0] CMD_ENDELSE = 4'd10;

    localparam logic [KIND_W-1:0] KIND_ARITH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PRINT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COND  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DIVZ  = 3'd4;

    localparam logic [CMP_W-1:0] CMP_GT = 3'd0;
    localparam logic [CMP_W-1:0] CMP_LT = 3'd1;
    localparam logic [CMP_W-1:0] CMP_EQ = 3'd2;
    localparam logic [CMP_W-1:0] CMP_NE = 3'd3;

    localparam logic [JOIN_W-1:0] JOIN_FIRST = 2'd0;
    localparam logic [JOIN_W-1:0] JOIN_NOT   = 2'd1;
    localparam logic [JOIN_W-1:0] JOIN_AND   = 2'd2;
    localparam logic [JOIN_W-1:0] JOIN_OR    = 2'd3;

    typedef enum logic [1:0] {
        SKIP_NONE,
        SKIP_IF,
        SKIP_ELSE
    } t_skip;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load_item;
        logic rd_en;
        logic rd_sel;
        logic lat_ab;
        logic exec;
        logic div_take;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             truth;
        logic             b_zero;
        logic             div_done;
        logic             has_res;
    } t_dp_sts;

    function automatic logic compare(input logic signed [DATA_W-1:0] x,
                                     input logic [CMP_W-1:0] code,
                                     input logic signed [DATA_W-1:0] y);
        logic res;
        unique case (code)
            CMP_GT:  res = x > y;
            CMP_LT:  res = x < y;
            CMP_EQ:  res = x == y;
            CMP_NE:  res = x != y;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lri_if.sv
// ---------------------------------------------------------------------------
// lri_if
// instruction and result channels with valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface lri_in_if import lri_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic                     first_is_var;
    logic signed [DATA_W-1:0] first_val;
    logic                     second_is_var;
    logic signed [DATA_W-1:0] second_val;
    logic                     third_is_var;
    logic signed [DATA_W-1:0] third_val;
    logic                     fourth_is_var;
    logic signed [DATA_W-1:0] fourth_val;
    logic [CMP_W-1:0]         cmp_left;
    logic [CMP_W-1:0]         cmp_right;
    logic [JOIN_W-1:0]        join_op;

    modport source (
        output valid, cmd, first_is_var, first_val, second_is_var, second_val,
               third_is_var, third_val, fourth_is_var, fourth_val,
               cmp_left, cmp_right, join_op,
        input  ready
    );
    modport sink (
        input  valid, cmd, first_is_var, first_val, second_is_var, second_val,
               third_is_var, third_val, fourth_is_var, fourth_val,
               cmp_left, cmp_right, join_op,
        output ready
    );
endinterface

interface lri_out_if import lri_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] remainder;
    logic [VIDX_W-1:0]        var_index;
    logic                     truth;

    modport source (
        output valid, kind, value, remainder, var_index, truth,
        input  ready
    );
    modport sink (
        input  valid, kind, value, remainder, var_index, truth,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/lri_div.sv
// ---------------------------------------------------------------------------
// lri_div
// signed 32-bit restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module lri_div import lri_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [DATA_W-1:0] i_num,
    input  wire logic signed [DATA_W-1:0] i_den,
    output logic                          o_done,
    output logic signed [DATA_W-1:0]      o_quo,
    output logic signed [DATA_W-1:0]      o_rem
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_nq;
    logic              r_nr;

    logic [DATA_W:0]   n_shift;
    logic [DATA_W:0]   n_diff;
    logic              n_ge;

    always_comb begin
        n_shift = {r_rem, r_quo[DATA_W-1]};
        n_diff  = n_shift - {1'b0, r_den};
        n_ge    = n_shift >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num[DATA_W-1] ? -i_num : i_num;
            r_den <= i_den[DATA_W-1] ? -i_den : i_den;
            r_nq  <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
            r_nr  <= i_num[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[DATA_W-1:0] : n_shift[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_nq ? -r_quo : r_quo;
    assign o_rem  = r_nr ? -r_rem : r_rem;

endmodule

`default_nettype wire

>>> rtl/core/lri_datapath.sv
// ---------------------------------------------------------------------------
// lri_datapath
// variable file, operand fetch, alu, divider and result register
// ---------------------------------------------------------------------------
`default_nettype none

module lri_datapath import lri_pkg::*; #(
    parameter int NUM_VARS = NUM_VARS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_sts                       o_sts,
    input  wire logic [CMD_W-1:0]         i_cmd_code,
    input  wire logic                     i_first_is_var,
    input  wire logic signed [DATA_W-1:0] i_first_val,
    input  wire logic                     i_second_is_var,
    input  wire logic signed [DATA_W-1:0] i_second_val,
    input  wire logic                     i_third_is_var,
    input  wire logic signed [DATA_W-1:0] i_third_val,
    input  wire logic                     i_fourth_is_var,
    input  wire logic signed [DATA_W-1:0] i_fourth_val,
    input  wire logic [CMP_W-1:0]         i_cmp_left,
    input  wire logic [CMP_W-1:0]         i_cmp_right,
    input  wire logic [JOIN_W-1:0]        i_join_op,
    output logic [KIND_W-1:0]             o_kind,
    output logic signed [DATA_W-1:0]      o_value,
    output logic signed [DATA_W-1:0]      o_remainder,
    output logic [VIDX_W-1:0]             o_var_index,
    output logic                          o_truth
);

    localparam int IDX_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

    // captured item
    logic [CMD_W-1:0]         r_cmd;
    logic                     r_dvar;
    logic [IDX_W-1:0]         r_didx;
    logic                     r_v1;
    logic signed [DATA_W-1:0] r_x1;
    logic                     r_v2;
    logic signed [DATA_W-1:0] r_x2;
    logic                     r_v3;
    logic signed [DATA_W-1:0] r_x3;
    logic                     r_v4;
    logic signed [DATA_W-1:0] r_x4;
    logic [CMP_W-1:0]         r_cl;
    logic [CMP_W-1:0]         r_cr;
    logic [JOIN_W-1:0]        r_join;

    // variable file
    logic [DATA_W-1:0]        r_mem [NUM_VARS];
    logic [NUM_VARS-1:0]      r_vld;
    logic signed [DATA_W-1:0] r_q0;
    logic signed [DATA_W-1:0] r_q1;
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_b;

    // pending result
    logic                     r_has;
    logic                     r_we;
    logic [KIND_W-1:0]        r_kind;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] r_rem;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_tr;

    logic                     w_v0;
    logic signed [DATA_W-1:0] w_x0;
    logic                     w_v1;
    logic signed [DATA_W-1:0] w_x1;
    logic                     w_ok0;
    logic                     w_ok1;
    logic [IDX_W-1:0]         w_ad0;
    logic [IDX_W-1:0]         w_ad1;
    logic                     w_cl;
    logic                     w_cr;
    logic                     w_truth;
    logic                     w_isdiv;
    logic                     w_div_done;
    logic signed [DATA_W-1:0] w_quo;
    logic signed [DATA_W-1:0] w_drem;
    logic [2*DATA_W-1:0]      w_prod;

    always_comb begin
        w_v0  = i_cmd.rd_sel ? r_v3 : r_v1;
        w_x0  = i_cmd.rd_sel ? r_x3 : r_x1;
        w_v1  = i_cmd.rd_sel ? r_v4 : r_v2;
        w_x1  = i_cmd.rd_sel ? r_x4 : r_x2;
        w_ok0 = w_v0 && ($unsigned(w_x0) < DATA_W'(NUM_VARS));
        w_ok1 = w_v1 && ($unsigned(w_x1) < DATA_W'(NUM_VARS));
        w_ad0 = w_x0[IDX_W-1:0];
        w_ad1 = w_x1[IDX_W-1:0];
    end

    always_comb begin
        w_cl = compare(r_a, r_cl, r_b);
        w_cr = compare(r_q0, r_cr, r_q1);
        unique case (r_join)
            JOIN_FIRST: w_truth = w_cl;
            JOIN_NOT:   w_truth = !w_cl && !w_cr;
            JOIN_AND:   w_truth = w_cl && w_cr;
            JOIN_OR:    w_truth = w_cl || w_cr;
            default:    w_truth = w_cl;
        endcase
        w_isdiv = (r_cmd == CMD_DIV) || (r_cmd == CMD_MOD);
        w_prod  = $unsigned(r_a) * $unsigned(r_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd  <= i_cmd_code;
            r_dvar <= i_first_is_var && ($unsigned(i_first_val) < DATA_W'(NUM_VARS));
            r_didx <= i_first_val[IDX_W-1:0];
            r_v1   <= i_first_is_var;
            r_x1   <= i_first_val;
            r_v2   <= i_second_is_var;
            r_x2   <= i_second_val;
            r_v3   <= i_third_is_var;
            r_x3   <= i_third_val;
            r_v4   <= i_fourth_is_var;
            r_x4   <= i_fourth_val;
            r_cl   <= i_cmp_left;
            r_cr   <= i_cmp_right;
            r_join <= i_join_op;
        end
    end

    // operand fetch, immediates pass through the read register
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_q0 <= w_ok0 ? (r_vld[w_ad0] ? r_mem[w_ad0] : '0) : (w_v0 ? '0 : w_x0);
            r_q1 <= w_ok1 ? (r_vld[w_ad1] ? r_mem[w_ad1] : '0) : (w_v1 ? '0 : w_x1);
        end
        if (i_cmd.lat_ab) begin
            r_a <= r_q0;
            r_b <= r_q1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_we) begin
            r_mem[r_idx] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.commit && r_we) begin
            r_vld[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has <= 1'b0;
            r_we  <= 1'b0;
        end else if (i_cmd.exec) begin
            r_has <= 1'b1;
            r_we  <= 1'b0;
            r_rem <= '0;
            r_idx <= r_dvar ? r_didx : '0;
            r_tr  <= 1'b0;
            unique case (r_cmd)
                CMD_LOAD: begin
                    r_kind <= KIND_LOAD;
                    r_val  <= r_b;
                    r_we   <= r_dvar;
                end
                CMD_PRINT: begin
                    r_kind <= KIND_PRINT;
                    r_val  <= r_a;
                    r_has  <= r_dvar;
                end
                CMD_ADD, CMD_SUB, CMD_MUL: begin
                    r_kind <= KIND_ARITH;
                    r_we   <= r_dvar;
                    if (r_cmd == CMD_ADD) begin
                        r_val <= r_a + r_b;
                    end else if (r_cmd == CMD_SUB) begin
                        r_val <= r_a - r_b;
                    end else begin
                        r_val <= w_prod[DATA_W-1:0];
                    end
                end
                CMD_DIV, CMD_MOD: begin
                    r_kind <= KIND_DIVZ;
                    r_val  <= '0;
                end
                CMD_IF: begin
                    r_kind <= KIND_COND;
                    r_val  <= '0;
                    r_idx  <= '0;
                    r_tr   <= w_truth;
                end
                default: begin
                    r_kind <= KIND_ARITH;
                    r_val  <= '0;
                    r_has  <= 1'b0;
                end
            endcase
        end else if (i_cmd.div_take) begin
            r_kind <= KIND_ARITH;
            r_we   <= r_dvar;
            r_val  <= (r_cmd == CMD_DIV) ? w_quo : w_drem;
            r_rem  <= (r_cmd == CMD_DIV) ? w_drem : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_kind      <= r_kind;
            o_value     <= r_val;
            o_remainder <= r_rem;
            o_var_index <= VIDX_W'(r_idx);
            o_truth     <= r_tr;
        end
    end

    lri_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.exec && w_isdiv && (r_b != '0)),
        .i_num   (r_a),
        .i_den   (r_b),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_drem)
    );

    always_comb begin
        o_sts.cmd      = r_cmd;
        o_sts.truth    = w_truth;
        o_sts.b_zero   = (r_b == '0);
        o_sts.div_done = w_div_done;
        o_sts.has_res  = r_has;
    end

endmodule

`default_nettype wire

>>> rtl/core/lri_ctrl.sv
// ---------------------------------------------------------------------------
// lri_ctrl
// sequencer, if/else skip tracking and output valid
// ---------------------------------------------------------------------------
`default_nettype none

module lri_ctrl import lri_pkg::*; #(
    parameter int NEST_LIMIT = NEST_LIMIT_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam int DEPTH_W = $clog2(NEST_LIMIT + 1);

    t_state             r_state;
    t_state             n_state;
    t_skip              r_mode;
    logic [DEPTH_W-1:0] r_depth;
    logic               r_pend;
    logic               r_out_vld;

    logic [CMD_W-1:0]   w_open;
    logic [CMD_W-1:0]   w_close;
    logic               w_free;

    always_comb begin
        w_open  = (r_mode == SKIP_IF) ? CMD_IF : CMD_ELSE;
        w_close = (r_mode == SKIP_IF) ? CMD_ENDIF : CMD_ENDELSE;
        w_free  = !r_out_vld || i_out_ready;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DEC;
            S_DEC: begin
                if (r_mode == SKIP_NONE && i_sts.cmd <= CMD_IF) begin
                    n_state = S_RD1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_EXEC;
            S_EXEC: begin
                if ((i_sts.cmd == CMD_DIV || i_sts.cmd == CMD_MOD) && !i_sts.b_zero) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV:  if (i_sts.div_done) n_state = S_FIN;
            S_FIN:  if (!i_sts.has_res || w_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            S_RD1: begin
                o_cmd.rd_en = 1'b1;
            end
            S_RD2: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = 1'b1;
                o_cmd.lat_ab = 1'b1;
            end
            S_EXEC: o_cmd.exec     = 1'b1;
            S_DIV:  o_cmd.div_take = i_sts.div_done;
            S_FIN:  o_cmd.commit   = i_sts.has_res && w_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= SKIP_NONE;
            r_depth   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (r_state == S_DEC) begin
                r_pend <= 1'b0;
                if (r_mode != SKIP_NONE) begin
                    if (i_sts.cmd == w_open) begin
                        if (r_depth < DEPTH_W'(NEST_LIMIT)) r_depth <= r_depth + 1'b1;
                    end else if (i_sts.cmd == w_close) begin
                        if (r_depth <= DEPTH_W'(1)) begin
                            r_depth <= '0;
                            r_mode  <= SKIP_NONE;
                        end else begin
                            r_depth <= r_depth - 1'b1;
                        end
                    end
                end else if (i_sts.cmd == CMD_ENDIF) begin
                    r_pend <= 1'b1;
                end else if (i_sts.cmd == CMD_ELSE && r_pend) begin
                    r_mode  <= SKIP_ELSE;
                    r_depth <= DEPTH_W'(1);
                end
            end
            if (r_state == S_EXEC && i_sts.cmd == CMD_IF && !i_sts.truth) begin
                r_mode  <= SKIP_IF;
                r_depth <= DEPTH_W'(1);
            end
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

>>> rtl/core/letter_register_interpreter_unit.sv
// ---------------------------------------------------------------------------
// letter_register_interpreter_unit
// executes decoded instructions over a file of signed 32-bit variables
// ---------------------------------------------------------------------------
// i_in carries one decoded instruction per transfer, o_out at most one result.
// The block works on one instruction at a time. ENDIF, ELSE, ENDELSE, no-op
// and any instruction met while skipping pass only through the decode state.
// LOAD, PRINT, ADD, SUB, MUL and IF pass through a decode state, two
// variable file reads, an execute state and a commit state. DIV and MOD
// also wait in a divide state after execute while the divider resolves one
// quotient bit per cycle; with a zero divisor they skip that wait.
// The result is written to the output register on commit and the next
// instruction is taken while it waits there. If the receiver stalls, a further
// result waits in the commit state until the output register frees, and no
// new instruction is taken meanwhile. Reset clears every variable to zero,
// leaves normal execution, drops any pending ENDIF and empties the output.
// ---------------------------------------------------------------------------
`default_nettype none

module letter_register_interpreter_unit import lri_pkg::*; #(
    parameter int NUM_VARS   = NUM_VARS_DEF,
    parameter int NEST_LIMIT = NEST_LIMIT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lri_in_if.sink    i_in,
    lri_out_if.source o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lri_ctrl #(
        .NEST_LIMIT (NEST_LIMIT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lri_datapath #(
        .NUM_VARS (NUM_VARS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cmd_code      (i_in.cmd),
        .i_first_is_var  (i_in.first_is_var),
        .i_first_val     (i_in.first_val),
        .i_second_is_var (i_in.second_is_var),
        .i_second_val    (i_in.second_val),
        .i_third_is_var  (i_in.third_is_var),
        .i_third_val     (i_in.third_val),
        .i_fourth_is_var (i_in.fourth_is_var),
        .i_fourth_val    (i_in.fourth_val),
        .i_cmp_left      (i_in.cmp_left),
        .i_cmp_right     (i_in.cmp_right),
        .i_join_op       (i_in.join_op),
        .o_kind          (o_out.kind),
        .o_value         (o_out.value),
        .o_remainder     (o_out.remainder),
        .o_var_index     (o_out.var_index),
        .o_truth         (o_out.truth)
    );

endmodule

`default_nettype wire

>>> rtl/core/lri_checker.sv
// ---------------------------------------------------------------------------
// lri_checker
// port-level checks of the interpreter, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "letter_register_interpreter_unit_macros.svh"

module lri_checker import lri_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     i_in_ready,
    input wire logic                     i_out_valid,
    input wire logic                     i_out_ready,
    input wire logic [KIND_W-1:0]        i_kind,
    input wire logic signed [DATA_W-1:0] i_value,
    input wire logic signed [DATA_W-1:0] i_remainder,
    input wire logic [VIDX_W-1:0]        i_var_index,
    input wire logic                     i_truth
);

    `LRI_ASSERT_NEXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready, "item taken twice")
    `LRI_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_value) && $stable(i_kind), "stalled result changed")
    `LRI_ASSERT_IMPL(a_cond_clean, i_out_valid && i_kind == KIND_COND, i_value == 0 && i_remainder == 0 && i_var_index == 0, "condition result carries data")
    `LRI_ASSERT_IMPL(a_truth_only_cond, i_out_valid && i_kind != KIND_COND, !i_truth, "truth set outside condition")
    `LRI_ASSERT_RST(a_reset_empty, !i_rst_n, !i_out_valid, "result valid after reset")

endmodule

bind letter_register_interpreter_unit lri_checker u_lri_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.kind),
    .i_value     (o_out.value),
    .i_remainder (o_out.remainder),
    .i_var_index (o_out.var_index),
    .i_truth     (o_out.truth)
);

`default_nettype wire

>>> sim/letter_register_interpreter_unit_tb.sv
// ---------------------------------------------------------------------------
// letter_register_interpreter_unit_tb
// self-checking bench: directed table, then random instruction streams with
// nested if/endif/else blocks, each result compared with a local predictor
// ---------------------------------------------------------------------------
`default_nettype none

module letter_register_interpreter_unit_tb;
    import lri_pkg::*;

    localparam int NVARS  = 26;
    localparam int NEST_MAX = 255;
    localparam int CMD_NOP = 11;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic                     av;
        logic signed [DATA_W-1:0] a;
        logic                     bv;
        logic signed [DATA_W-1:0] b;
        logic                     cv;
        logic signed [DATA_W-1:0] c;
        logic                     dv;
        logic signed [DATA_W-1:0] d;
        logic [CMP_W-1:0]         cl;
        logic [CMP_W-1:0]         cr;
        logic [JOIN_W-1:0]        jn;
    } t_instr;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] rem;
        logic [VIDX_W-1:0]        vidx;
        logic                     truth;
    } t_res;

    typedef struct {
        t_instr ins;
        bit     typed;
        t_res   res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fails = 0;

    lri_in_if  in_ch ();
    lri_out_if out_ch ();

    letter_register_interpreter_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [DATA_W-1:0] vars [NVARS];
    int   skip_st = 0;
    int   skip_lvl = 0;
    bit   endif_seen = 0;
    t_res pending_results [$];

    function automatic logic [DATA_W-1:0] fetch(logic isv, logic [DATA_W-1:0] raw);
        if (!isv) return raw;
        if (raw < NVARS) return vars[raw];
        return '0;
    endfunction

    function automatic bit relate(logic signed [DATA_W-1:0] x, logic [CMP_W-1:0] code,
                                  logic signed [DATA_W-1:0] y);
        case (code)
            CMP_GT: return x > y;
            CMP_LT: return x < y;
            CMP_EQ: return x == y;
            CMP_NE: return x != y;
            default: return 0;
        endcase
    endfunction

    // returns 1 when a result is produced
    function automatic bit interpret(t_instr t, output t_res r);
        bit had_endif;
        bit dst_ok;
        logic [4:0] di;
        logic signed [DATA_W-1:0] x, y, q, m, rv;
        bit l, rr, tr;
        had_endif = endif_seen;
        endif_seen = 0;
        r = '{default: '0};
        if (skip_st != 0) begin
            if (t.cmd == (skip_st == 1 ? CMD_IF : CMD_ELSE)) begin
                if (skip_lvl < NEST_MAX) skip_lvl++;
            end else if (t.cmd == (skip_st == 1 ? CMD_ENDIF : CMD_ENDELSE)) begin
                if (skip_lvl > 0) skip_lvl--;
                if (skip_lvl == 0) skip_st = 0;
            end
            return 0;
        end
        dst_ok = t.av && ($unsigned(t.a) < NVARS);
        di = dst_ok ? t.a[4:0] : '0;
        x = fetch(t.av, t.a);
        y = fetch(t.bv, t.b);
        case (t.cmd)
            CMD_LOAD: begin
                if (dst_ok) vars[di] = y;
                r = '{KIND_LOAD, y, 0, di, 0};
                return 1;
            end
            CMD_PRINT: begin
                if (!dst_ok) return 0;
                r = '{KIND_PRINT, vars[di], 0, di, 0};
                return 1;
            end
            CMD_ADD, CMD_SUB, CMD_MUL: begin
                rv = t.cmd == CMD_ADD ? x + y : t.cmd == CMD_SUB ? x - y : x * y;
                if (dst_ok) vars[di] = rv;
                r = '{KIND_ARITH, rv, 0, di, 0};
                return 1;
            end
            CMD_DIV, CMD_MOD: begin
                if (y == 0) begin
                    r = '{KIND_DIVZ, 0, 0, di, 0};
                    return 1;
                end
                if (x == 32'sh80000000 && y == -1) begin
                    q = x;
                    m = 0;
                end else begin
                    q = x / y;
                    m = x % y;
                end
                rv = t.cmd == CMD_DIV ? q : m;
                if (dst_ok) vars[di] = rv;
                r = '{KIND_ARITH, rv, (t.cmd == CMD_DIV ? m : 0), di, 0};
                return 1;
            end
            CMD_IF: begin
                l = relate(x, t.cl, y);
                rr = relate(fetch(t.cv, t.c), t.cr, fetch(t.dv, t.d));
                case (t.jn)
                    JOIN_FIRST: tr = l;
                    JOIN_NOT:   tr = !l && !rr;
                    JOIN_AND:   tr = l && rr;
                    default:    tr = l || rr;
                endcase
                if (!tr) begin
                    skip_st = 1;
                    skip_lvl = 1;
                end
                r = '{KIND_COND, 0, 0, 0, tr};
                return 1;
            end
            CMD_ENDIF: begin
                endif_seen = 1;
                return 0;
            end
            CMD_ELSE: begin
                if (had_endif) begin
                    skip_st = 2;
                    skip_lvl = 1;
                end
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(5))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return -1;
            3: return $urandom_range(NVARS + 2);
            4: return $signed($urandom_range(200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_instr rand_instr(logic [CMD_W-1:0] c);
        t_instr t;
        t.cmd = c;
        t.av = $urandom_range(9) != 0;
        t.a = t.av && $urandom_range(7) != 0 ? $urandom_range(NVARS - 1) : rand_word();
        t.bv = $urandom_range(1);
        t.b = t.bv && $urandom_range(7) != 0 ? $urandom_range(NVARS - 1) : rand_word();
        t.cv = $urandom_range(1);
        t.c = t.cv ? $urandom_range(NVARS - 1) : rand_word();
        t.dv = $urandom_range(1);
        t.d = t.dv ? $urandom_range(NVARS - 1) : rand_word();
        t.cl = $urandom_range(7);
        t.cr = $urandom_range(7);
        t.jn = $urandom_range(3);
        return t;
    endfunction

    function automatic logic [CMD_W-1:0] rand_cmd();
        int p;
        p = $urandom_range(99);
        if (p < 60) return $urandom_range(CMD_MOD);
        if (p < 75) return CMD_IF;
        if (p < 83) return CMD_ENDIF;
        if (p < 90) return CMD_ELSE;
        if (p < 96) return CMD_ENDELSE;
        return $urandom_range(CMD_NOP, 15);
    endfunction

    function automatic t_instr mk(logic [CMD_W-1:0] c, logic av, int a, logic bv, int b);
        t_instr t;
        t = '{c, av, a, bv, b, 0, 0, 0, 0, CMP_GT, CMP_GT, JOIN_FIRST};
        return t;
    endfunction

    function automatic t_instr mk_if(int a, logic [CMP_W-1:0] cl, int b, int c,
                                     logic [CMP_W-1:0] cr, int d, logic [JOIN_W-1:0] jn);
        t_instr t;
        t = '{CMD_IF, 0, a, 0, b, 0, c, 0, d, cl, cr, jn};
        return t;
    endfunction

    task automatic send(t_instr t, bit typed, t_res want);
        t_res r;
        int gap;
        gap = $urandom_range(99) < 80 ? $urandom_range(1, 3) : $urandom_range(1, 40);
        repeat (gap) @(negedge i_clk);
        if (interpret(t, r)) begin
            if (typed && r != want) begin
                $error("table row kind/value: expected %0d/%0d got %0d/%0d",
                       want.kind, want.value, r.kind, r.value);
                fails++;
            end
            pending_results.push_back(typed ? want : r);
        end
        in_ch.cmd <= t.cmd;
        in_ch.first_is_var <= t.av;
        in_ch.first_val <= t.a;
        in_ch.second_is_var <= t.bv;
        in_ch.second_val <= t.b;
        in_ch.third_is_var <= t.cv;
        in_ch.third_val <= t.c;
        in_ch.fourth_is_var <= t.dv;
        in_ch.fourth_val <= t.d;
        in_ch.cmp_left <= t.cl;
        in_ch.cmp_right <= t.cr;
        in_ch.join_op <= t.jn;
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // result checking
    bit stall_mode = 0;
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result kind %0d", out_ch.kind);
                fails++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.kind !== want.kind) begin
                    $error("kind: expected %0d got %0d", want.kind, out_ch.kind);
                    fails++;
                end
                if (out_ch.value !== want.value) begin
                    $error("value: expected %0d got %0d", want.value, out_ch.value);
                    fails++;
                end
                if (out_ch.remainder !== want.rem) begin
                    $error("remainder: expected %0d got %0d", want.rem, out_ch.remainder);
                    fails++;
                end
                if (out_ch.var_index !== want.vidx) begin
                    $error("var_index: expected %0d got %0d", want.vidx, out_ch.var_index);
                    fails++;
                end
                if (out_ch.truth !== want.truth) begin
                    $error("truth: expected %0d got %0d", want.truth, out_ch.truth);
                    fails++;
                end
            end
        end
    end

    // receiver stalls
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!stall_mode || $urandom_range(99) < 70) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(99) < 85 ? $urandom_range(1, 3) : $urandom_range(4, 50))
                    @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #40_000_000;
        $display("[letter_register_interpreter_unit] ERROR");
        $finish;
    end

    initial begin
        t_row   rows [$];
        t_res   none;
        t_instr t;
        int     sent;
        int     depth;
        int     n;
        bit     drained;
        none = '{default: '0};
        for (int k = 0; k < NVARS; k++) vars[k] = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = '0;
        in_ch.first_is_var = 1'b0;
        in_ch.first_val = '0;
        in_ch.second_is_var = 1'b0;
        in_ch.second_val = '0;
        in_ch.third_is_var = 1'b0;
        in_ch.third_val = '0;
        in_ch.fourth_is_var = 1'b0;
        in_ch.fourth_val = '0;
        in_ch.cmp_left = '0;
        in_ch.cmp_right = '0;
        in_ch.join_op = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        rows = '{
            '{mk(CMD_PRINT, 1, 25, 0, 0), 1, '{KIND_PRINT, 0, 0, 25, 0}},
            '{mk(CMD_LOAD, 1, 0, 0, 32'sh80000000), 1, '{KIND_LOAD, 32'sh80000000, 0, 0, 0}},
            '{mk(CMD_LOAD, 1, 25, 0, 32'sh7fffffff), 1, '{KIND_LOAD, 32'sh7fffffff, 0, 25, 0}},
            '{mk(CMD_LOAD, 1, 26, 0, 5), 1, '{KIND_LOAD, 5, 0, 0, 0}},
            '{mk(CMD_LOAD, 1, 1, 1, -1), 1, '{KIND_LOAD, 0, 0, 1, 0}},
            '{mk(CMD_ADD, 1, 25, 0, 1), 1, '{KIND_ARITH, 32'sh80000000, 0, 25, 0}},
            '{mk(CMD_SUB, 0, 3, 1, 0), 0, none},
            '{mk(CMD_MUL, 1, 2, 0, 7), 1, '{KIND_ARITH, 0, 0, 2, 0}},
            '{mk(CMD_DIV, 1, 0, 0, -1), 1, '{KIND_ARITH, 32'sh80000000, 0, 0, 0}},
            '{mk(CMD_DIV, 1, 3, 0, 0), 1, '{KIND_DIVZ, 0, 0, 3, 0}},
            '{mk(CMD_MOD, 1, 4, 1, 9), 1, '{KIND_DIVZ, 0, 0, 4, 0}},
            '{mk(CMD_LOAD, 1, 5, 0, -7), 0, none},
            '{mk(CMD_DIV, 1, 5, 0, 2), 0, none},
            '{mk(CMD_MOD, 1, 5, 0, -2), 0, none},
            '{mk(CMD_PRINT, 0, 5, 0, 0), 0, none},
            '{mk_if(1, CMP_GT, 2, 0, CMP_GT, 0, JOIN_FIRST), 1, '{KIND_COND, 0, 0, 0, 0}},
            '{mk(CMD_IF, 0, 0, 0, 0), 0, none},
            '{mk(CMD_ENDIF, 0, 0, 0, 0), 0, none},
            '{mk(CMD_ENDIF, 0, 0, 0, 0), 0, none},
            '{mk(CMD_ELSE, 0, 0, 0, 0), 0, none},
            '{mk_if(1, 3'd5, 1, 2, CMP_LT, 1, JOIN_NOT), 1, '{KIND_COND, 0, 0, 0, 1}},
            '{mk(CMD_ENDIF, 0, 0, 0, 0), 0, none},
            '{mk(CMD_ELSE, 0, 0, 0, 0), 0, none},
            '{mk_if(3, CMP_EQ, 3, 4, CMP_NE, 4, JOIN_AND), 0, none},
            '{mk(CMD_ENDELSE, 0, 0, 0, 0), 0, none},
            '{mk_if(3, CMP_NE, 3, 4, CMP_NE, 5, JOIN_OR), 1, '{KIND_COND, 0, 0, 0, 1}}
        };
        foreach (rows[k]) send(rows[k].ins, rows[k].typed, rows[k].res);

        stall_mode = 1;
        sent = 0;
        depth = 0;
        drained = 0;
        while (sent < 1450) begin
            if (sent >= 700 && !drained) begin
                // drain everything before going on
                while (pending_results.size() != 0) @(posedge i_clk);
                drained = 1;
            end
            if ($urandom_range(99) < 70) begin
                // well formed block, sometimes with else
                send(rand_instr(CMD_IF), 0, none);
                n = $urandom_range(3);
                repeat (n) send(rand_instr($urandom_range(CMD_MOD)), 0, none);
                sent += n;
                if ($urandom_range(3) == 0) begin
                    send(rand_instr(CMD_IF), 0, none);
                    send(rand_instr($urandom_range(CMD_MOD)), 0, none);
                    send(rand_instr(CMD_ENDIF), 0, none);
                    sent += 3;
                end
                send(rand_instr(CMD_ENDIF), 0, none);
                sent += 2;
                if ($urandom_range(1)) begin
                    send(rand_instr(CMD_ELSE), 0, none);
                    n = $urandom_range(1, 3);
                    repeat (n)
                        send(rand_instr($urandom_range(CMD_MOD)), 0, none);
                    send(rand_instr(CMD_ENDELSE), 0, none);
                    sent += n + 2;
                end
            end else begin
                send(rand_instr(rand_cmd()), 0, none);
                sent++;
            end
            if (skip_st != 0 && $urandom_range(3) == 0) begin
                // close stray skips so execution continues
                t = rand_instr(skip_st == 1 ? CMD_ENDIF : CMD_ENDELSE);
                send(t, 0, none);
                sent++;
            end
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fails == 0) begin
            $display("[letter_register_interpreter_unit] OK");
        end else begin
            $display("[letter_register_interpreter_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/lri_pkg.sv
rtl/core/lri_if.sv
rtl/core/lri_div.sv
rtl/core/lri_datapath.sv
rtl/core/lri_ctrl.sv
rtl/core/letter_register_interpreter_unit.sv
rtl/core/lri_checker.sv
sim/letter_register_interpreter_unit_tb.sv
